### hw/rtl/unpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unpm_pkg
// Shared constants and types for the BGRA un-premultiply core.
// ----------------------------------------------------------------------------
package unpm_pkg;

  localparam int FRAC_BITS = 8;
  localparam int IN_W      = 8;
  localparam int OUT_W     = 16;

  // 255.0 in fixed point and its width.
  localparam int TOP_W = IN_W + FRAC_BITS;
  localparam logic [TOP_W-1:0] TOP_VAL = TOP_W'(255) << FRAC_BITS;

  // Dividend 2*c*TOP + a fits in N_W bits; the reciprocal keeps as many.
  localparam int N_W   = 2 * IN_W + 1 + FRAC_BITS;
  localparam int RCP_K = N_W;
  localparam int RCP_W = RCP_K;
  localparam int D_W   = IN_W + 1;
  localparam int Q_W   = TOP_W + 1;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;
  localparam logic [Q_W-1:0]   SAT_VAL = (Q_W'(TOP_VAL) > Q_W'(OUT_MAX)) ?
                                         Q_W'(OUT_MAX) : Q_W'(TOP_VAL);

  typedef struct packed {
    logic en1;
    logic en2;
  } ctrl_t;

endpackage

### hw/rtl/bgra_unpremultiply_to_planar_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgra_unpremultiply_to_planar_core
// BGRA pixel to fixed-point red, green and blue with optional un-premultiply.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock unless a stalled output holds it; each pixel
// passes through stage 1, stage 2 and the output register. Each channel has its
// own lane; the three lanes share one reciprocal table indexed by alpha, so the
// division becomes one multiply, one check multiply and a single correction step.
// A stalled output fills the pipeline's bubbles before input backs up.
module bgra_unpremultiply_to_planar_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // blue_in, green_in, red_in, alpha_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [3*unpm_pkg::OUT_W-1:0] m_tdata  // red_out, green_out, blue_out
);
  import unpm_pkg::*;

  logic                 mode;
  logic                 v1, v2;
  logic                 en3;
  ctrl_t                ctrl;
  logic [RCP_W-1:0]     recip;
  logic [IN_W-1:0]      blue_in, green_in, red_in, alpha_in;
  logic [OUT_W-1:0]     red_res, green_res, blue_res;

  assign blue_in  = s_tdata[7:0];
  assign green_in = s_tdata[15:8];
  assign red_in   = s_tdata[23:16];
  assign alpha_in = s_tdata[31:24];

  assign ctrl.en2 = !v2 || en3;
  assign ctrl.en1 = !v1 || ctrl.en2;
  assign s_tready = ctrl.en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b1;
    end else if (cfg_wen) begin
      mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ctrl.en1) begin
        v1 <= s_tvalid;
      end
      if (ctrl.en2) begin
        v2 <= v1;
      end
    end
  end

  unpm_recip u_recip (
    .clk   (clk),
    .en1   (ctrl.en1),
    .alpha (alpha_in),
    .recip (recip)
  );

  unpm_lane u_lane_r (
    .clk   (clk),
    .ctrl  (ctrl),
    .mode  (mode),
    .chan  (red_in),
    .alpha (alpha_in),
    .recip (recip),
    .res   (red_res)
  );

  unpm_lane u_lane_g (
    .clk   (clk),
    .ctrl  (ctrl),
    .mode  (mode),
    .chan  (green_in),
    .alpha (alpha_in),
    .recip (recip),
    .res   (green_res)
  );

  unpm_lane u_lane_b (
    .clk   (clk),
    .ctrl  (ctrl),
    .mode  (mode),
    .chan  (blue_in),
    .alpha (alpha_in),
    .recip (recip),
    .res   (blue_res)
  );

  unpm_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v2),
    .red      (red_res),
    .green    (green_res),
    .blue     (blue_res),
    .en3      (en3),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!v1 && !v2 && !m_tvalid))
    else $error("pipeline not empty after reset");

  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    (v2 && (!m_tvalid || m_tready)) |=> m_tvalid)
    else $error("finished pixel did not reach the output register");

  a_ready_bubble: assert property (@(posedge clk) disable iff (rst)
    (!v1 || !v2 || !m_tvalid) |-> s_tready)
    else $error("input stalled while the pipeline has a bubble");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (Q_W'(m_tdata[OUT_W-1:0]) <= SAT_VAL &&
                  Q_W'(m_tdata[2*OUT_W-1:OUT_W]) <= SAT_VAL &&
                  Q_W'(m_tdata[3*OUT_W-1:2*OUT_W]) <= SAT_VAL))
    else $error("output channel above full scale");
`endif

endmodule

### hw/rtl/unpm_recip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unpm_recip
// Reciprocal lookup of twice the alpha value, shared by all channel lanes.
// ----------------------------------------------------------------------------
module unpm_recip (
  input  logic                      clk,
  input  logic                      en1,
  input  logic [unpm_pkg::IN_W-1:0] alpha,
  output logic [unpm_pkg::RCP_W-1:0] recip
);
  import unpm_pkg::*;

  logic [RCP_W-1:0] tab [256];

  // Entry i holds floor(2^K / (2*i)); alpha of zero is handled in the lanes.
  assign tab[0] = '0;
  for (genvar i = 1; i < 256; i++) begin : g_tab
    localparam logic [63:0] RV = (64'd1 << RCP_K) / (64'd2 * i);
    assign tab[i] = RCP_W'(RV);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      recip <= tab[alpha];
    end
  end

endmodule

### hw/rtl/unpm_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unpm_lane
// One color channel: scale by 255/alpha, round to nearest, clamp; or pass through.
// ----------------------------------------------------------------------------
module unpm_lane (
  input  logic                        clk,
  input  unpm_pkg::ctrl_t             ctrl,
  input  logic                        mode,
  input  logic [unpm_pkg::IN_W-1:0]   chan,
  input  logic [unpm_pkg::IN_W-1:0]   alpha,
  input  logic [unpm_pkg::RCP_W-1:0]  recip,
  output logic [unpm_pkg::OUT_W-1:0]  res
);
  import unpm_pkg::*;

  logic [N_W-1:0]         n1, n2;
  logic [D_W-1:0]         d1, d2;
  logic [TOP_W-1:0]       st1, st2;
  logic                   zero1, zero2, sat1, sat2, mode1, mode2;
  logic [Q_W-1:0]         q2;
  logic [N_W+RCP_W-1:0]   prod;
  logic [Q_W+D_W-1:0]     pd;
  logic [Q_W+D_W-1:0]     rem;
  logic [Q_W-1:0]         qc;
  logic [Q_W-1:0]         val;

  always_ff @(posedge clk) begin
    if (ctrl.en1) begin
      n1    <= N_W'({chan, 1'b0}) * N_W'(TOP_VAL) + N_W'(alpha);
      d1    <= {alpha, 1'b0};
      st1   <= TOP_W'(chan) << FRAC_BITS;
      zero1 <= (alpha == '0);
      sat1  <= (chan >= alpha);
      mode1 <= mode;
    end
  end

  // The estimate from the truncated reciprocal is at most one below the quotient.
  assign prod = (N_W+RCP_W)'(n1) * (N_W+RCP_W)'(recip);

  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      q2    <= prod[RCP_K +: Q_W];
      n2    <= n1;
      d2    <= d1;
      st2   <= st1;
      zero2 <= zero1;
      sat2  <= sat1;
      mode2 <= mode1;
    end
  end

  always_comb begin
    pd  = (Q_W+D_W)'(q2) * (Q_W+D_W)'(d2);
    rem = (Q_W+D_W)'(n2) - pd;
    qc  = (rem >= (Q_W+D_W)'(d2)) ? q2 + Q_W'(1) : q2;
    if (!mode2) begin
      val = Q_W'(st2);
    end else if (zero2) begin
      val = '0;
    end else if (sat2) begin
      val = Q_W'(TOP_VAL);
    end else begin
      val = qc;
    end
    if (val > SAT_VAL) begin
      val = SAT_VAL;
    end
    res = OUT_W'(val);
  end

endmodule

### hw/rtl/unpm_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unpm_merge
// Joins the three lane results into one output beat and holds it.
// ----------------------------------------------------------------------------
module unpm_merge (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [unpm_pkg::OUT_W-1:0] red,
  input  logic [unpm_pkg::OUT_W-1:0] green,
  input  logic [unpm_pkg::OUT_W-1:0] blue,
  output logic                       en3,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [3*unpm_pkg::OUT_W-1:0] m_tdata  // red_out, green_out, blue_out
);
  import unpm_pkg::*;

  assign en3 = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en3) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      m_tdata <= {blue, green, red};
    end
  end

endmodule
